@@ design/abb_pkg.sv @@
// Shared types and codes for the box broadphase table.
package abb_pkg;

    localparam int SLOT_W = 6;
    localparam int STAT_W = 2;
    localparam int OP_W   = 3;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE  = 3'd0,
        OP_DESTROY = 3'd1,
        OP_SET     = 3'd2,
        OP_TEST    = 3'd3,
        OP_SWEEP   = 3'd4
    } abb_op_t;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NO_PAIR = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BAD     = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] new_slot;
        logic [SLOT_W-1:0] pair_first;
        logic [SLOT_W-1:0] pair_second;
        logic              overlaps;
        logic              last;
    } abb_res_t;

    typedef struct packed {
        logic wr;
        logic rd;
        logic hold_ref;
    } abb_box_ctl_t;

    typedef struct packed {
        logic fs_rd;
        logic fs_wr;
        logic al_rd;
        logic al_wr;
    } abb_list_ctl_t;

endpackage

@@ design/abb_box_unit.sv @@
// Box store with the shared closed-bound overlap comparator.
module abb_box_unit #(
    parameter int MAX_BOXES = 64,
    parameter int KW        = 32
) (
    input  logic                         aclk,
    input  abb_pkg::abb_box_ctl_t        ctl,
    input  logic [$clog2(MAX_BOXES)-1:0] wr_addr,
    input  logic [6*KW-1:0]              wr_data,
    input  logic [$clog2(MAX_BOXES)-1:0] rd_addr,
    output logic                         overlap
);
    import abb_pkg::*;

    localparam int IDX_W = $clog2(MAX_BOXES);
    localparam int BW    = 6 * KW;

    logic [BW-1:0] mem [MAX_BOXES];
    logic [BW-1:0] rd_data_reg;
    logic [BW-1:0] ref_reg;
    logic [2:0]    axis_ok;

    always_ff @(posedge aclk) begin
        if (ctl.wr) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (ctl.hold_ref) begin
            ref_reg <= rd_data_reg;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            axis_ok[k] =
                ($signed(ref_reg[k*KW +: KW]) <= $signed(rd_data_reg[(k+3)*KW +: KW])) &&
                ($signed(rd_data_reg[k*KW +: KW]) <= $signed(ref_reg[(k+3)*KW +: KW]));
        end
    end

    assign overlap = &axis_ok;

endmodule

@@ design/abb_slot_lists.sv @@
// Free-slot stack and dense active list memories.
module abb_slot_lists #(
    parameter int MAX_BOXES = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  abb_pkg::abb_list_ctl_t       ctl,
    input  logic [$clog2(MAX_BOXES)-1:0] fs_addr,
    input  logic [$clog2(MAX_BOXES)-1:0] fs_wr_data,
    output logic [$clog2(MAX_BOXES)-1:0] fs_rd_data,
    input  logic [$clog2(MAX_BOXES)-1:0] al_rd_addr,
    input  logic [$clog2(MAX_BOXES)-1:0] al_wr_addr,
    input  logic [$clog2(MAX_BOXES)-1:0] al_wr_data,
    output logic [$clog2(MAX_BOXES)-1:0] al_rd_data
);
    import abb_pkg::*;

    localparam int IDX_W = $clog2(MAX_BOXES);
    localparam int CNT_W = IDX_W + 1;

    logic [IDX_W-1:0] fs_mem [MAX_BOXES];
    logic [IDX_W-1:0] al_mem [MAX_BOXES];
    logic [IDX_W-1:0] fs_rd_reg;
    logic [IDX_W-1:0] al_rd_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             fs_seen;

    assign fs_seen = CNT_W'(fs_addr) < fill_reg;

    always_comb begin
        fill_next = fill_reg;
        if (ctl.fs_rd && !fs_seen) begin
            fill_next = CNT_W'(fs_addr) + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.fs_wr) begin
            fs_mem[fs_addr] <= fs_wr_data;
        end
        if (ctl.fs_rd) begin
            fs_rd_reg <= fs_seen ? fs_mem[fs_addr] : fs_addr;
        end
        if (ctl.al_wr) begin
            al_mem[al_wr_addr] <= al_wr_data;
        end
        if (ctl.al_rd) begin
            al_rd_reg <= al_mem[al_rd_addr];
        end
    end

    assign fs_rd_data = fs_rd_reg;
    assign al_rd_data = al_rd_reg;

endmodule

@@ design/aabb_broadphase_table.sv @@
// Top level of the box broadphase table: sequencer over the box store and slot lists.
//
// One command word is taken at a time; s_ready is high only while the sequencer is idle.
// Set, test and destroy scan the active list, checking one entry per cycle. A sweep
// steps through each later active entry; each partner needs an active-list read, a
// box read and one pass through the shared overlap comparator. Result words leave
// through an output register, so a word may wait on m_ready while the block keeps
// working up to the next result.
module aabb_broadphase_table #(
    parameter int MAX_BOXES  = 64,
    parameter int COORD_BITS = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [abb_pkg::OP_W-1:0]    s_opcode,
    input  logic signed [31:0]          s_min_x,
    input  logic signed [31:0]          s_min_y,
    input  logic signed [31:0]          s_min_z,
    input  logic signed [31:0]          s_max_x,
    input  logic signed [31:0]          s_max_y,
    input  logic signed [31:0]          s_max_z,
    input  logic [abb_pkg::SLOT_W-1:0]  s_slot_a,
    input  logic [abb_pkg::SLOT_W-1:0]  s_slot_b,
    input  logic [abb_pkg::SLOT_W-1:0]  s_row_position,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [abb_pkg::STAT_W-1:0]  m_status,
    output logic [abb_pkg::SLOT_W-1:0]  m_new_slot,
    output logic [abb_pkg::SLOT_W-1:0]  m_pair_first,
    output logic [abb_pkg::SLOT_W-1:0]  m_pair_second,
    output logic                        m_overlaps,
    output logic                        m_last
);
    import abb_pkg::*;

    localparam int IDX_W = $clog2(MAX_BOXES);
    localparam int CNT_W = IDX_W + 1;
    localparam int KW    = (COORD_BITS < 32) ? COORD_BITS : 32;
    localparam int BW    = 6 * KW;
    localparam int CW    = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam int RW    = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_CR_WR,
        ST_SCAN,
        ST_FOUND,
        ST_DST_MOVE,
        ST_TST_A,
        ST_TST_B,
        ST_SW_BASE,
        ST_SW_REF,
        ST_SW_LIST,
        ST_SW_BOX,
        ST_SW_CMP,
        ST_EMIT
    } state_t;

    function automatic abb_res_t mk_res(logic [STAT_W-1:0] st, logic [SLOT_W-1:0] ns,
                                        logic [SLOT_W-1:0] pf, logic [SLOT_W-1:0] ps,
                                        logic ov, logic lst);
        abb_res_t r;
        r.status      = st;
        r.new_slot    = ns;
        r.pair_first  = pf;
        r.pair_second = ps;
        r.overlaps    = ov;
        r.last        = lst;
        return r;
    endfunction

    state_t           state_reg, state_next, ret_reg, ret_next;
    abb_op_t          op_reg, op_next;
    logic [BW-1:0]    box_reg, box_next;
    logic [SLOT_W-1:0] sa_reg, sa_next, sb_reg, sb_next, row_reg, row_next;
    logic [CNT_W-1:0] top_reg, top_next, cnt_reg, cnt_next;
    logic [CNT_W-1:0] issue_reg, issue_next, j_reg, j_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             found_a_reg, found_a_next, found_b_reg, found_b_next;
    logic [IDX_W-1:0] pos_a_reg, pos_a_next;
    logic [IDX_W-1:0] base_reg, base_next, part_reg, part_next, pair_reg, pair_next;
    logic             have_reg, have_next;
    abb_res_t         res_reg, res_next, m_word_reg, m_word_next;
    logic             m_valid_reg, m_valid_next;

    abb_box_ctl_t     bctl;
    logic [IDX_W-1:0] box_wr_addr, box_rd_addr;
    logic [BW-1:0]    box_wr_data;
    logic             overlap;
    abb_list_ctl_t    lctl;
    logic [IDX_W-1:0] fs_addr, fs_wr_data, fs_rd_data;
    logic [IDX_W-1:0] al_rd_addr, al_wr_addr, al_wr_data, al_rd_data;
    logic             out_free;

    abb_box_unit #(.MAX_BOXES(MAX_BOXES), .KW(KW)) u_box (
        .aclk    (aclk),
        .ctl     (bctl),
        .wr_addr (box_wr_addr),
        .wr_data (box_wr_data),
        .rd_addr (box_rd_addr),
        .overlap (overlap)
    );

    abb_slot_lists #(.MAX_BOXES(MAX_BOXES)) u_lists (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (lctl),
        .fs_addr    (fs_addr),
        .fs_wr_data (fs_wr_data),
        .fs_rd_data (fs_rd_data),
        .al_rd_addr (al_rd_addr),
        .al_wr_addr (al_wr_addr),
        .al_wr_data (al_wr_data),
        .al_rd_data (al_rd_data)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        op_next      = op_reg;
        box_next     = box_reg;
        sa_next      = sa_reg;
        sb_next      = sb_reg;
        row_next     = row_reg;
        top_next     = top_reg;
        cnt_next     = cnt_reg;
        issue_next   = issue_reg;
        j_next       = j_reg;
        pend_next    = pend_reg;
        cmp_idx_next = cmp_idx_reg;
        found_a_next = found_a_reg;
        found_b_next = found_b_reg;
        pos_a_next   = pos_a_reg;
        base_next    = base_reg;
        part_next    = part_reg;
        pair_next    = pair_reg;
        have_next    = have_reg;
        res_next     = res_reg;
        m_word_next  = m_word_reg;
        m_valid_next = m_valid_reg && !m_ready;

        bctl        = '0;
        box_wr_addr = IDX_W'(sa_reg);
        box_wr_data = box_reg;
        box_rd_addr = IDX_W'(sa_reg);
        lctl        = '0;
        fs_addr     = top_reg[IDX_W-1:0];
        fs_wr_data  = IDX_W'(sa_reg);
        al_rd_addr  = issue_reg[IDX_W-1:0];
        al_wr_addr  = cnt_reg[IDX_W-1:0];
        al_wr_data  = fs_rd_data;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next      = abb_op_t'(s_opcode);
                    box_next     = {s_max_z[KW-1:0], s_max_y[KW-1:0], s_max_x[KW-1:0],
                                    s_min_z[KW-1:0], s_min_y[KW-1:0], s_min_x[KW-1:0]};
                    sa_next      = s_slot_a;
                    sb_next      = s_slot_b;
                    row_next     = s_row_position;
                    issue_next   = '0;
                    pend_next    = 1'b0;
                    found_a_next = 1'b0;
                    found_b_next = 1'b0;
                    have_next    = 1'b0;
                    state_next   = ST_START;
                end
            end
            ST_START: begin
                ret_next = ST_IDLE;
                case (op_reg)
                    OP_CREATE: begin
                        if (cnt_reg >= CNT_W'(MAX_BOXES) || top_reg >= CNT_W'(MAX_BOXES)) begin
                            res_next   = mk_res(STAT_FULL, '0, '0, '0, 1'b0, 1'b1);
                            state_next = ST_EMIT;
                        end else begin
                            lctl.fs_rd = 1'b1;
                            state_next = ST_CR_WR;
                        end
                    end
                    OP_DESTROY, OP_SET, OP_TEST: begin
                        state_next = ST_SCAN;
                    end
                    OP_SWEEP: begin
                        if (RW'(row_reg) >= RW'(cnt_reg)) begin
                            res_next   = mk_res(STAT_BAD, '0, '0, '0, 1'b0, 1'b1);
                            state_next = ST_EMIT;
                        end else begin
                            lctl.al_rd = 1'b1;
                            al_rd_addr = IDX_W'(row_reg);
                            state_next = ST_SW_BASE;
                        end
                    end
                    default: begin
                        res_next   = mk_res(STAT_BAD, '0, '0, '0, 1'b0, 1'b1);
                        state_next = ST_EMIT;
                    end
                endcase
            end
            ST_CR_WR: begin
                bctl.wr     = 1'b1;
                box_wr_addr = fs_rd_data;
                lctl.al_wr  = 1'b1;
                top_next    = top_reg + CNT_W'(1);
                cnt_next    = cnt_reg + CNT_W'(1);
                res_next    = mk_res(STAT_OK, SLOT_W'(fs_rd_data), '0, '0, 1'b0, 1'b1);
                state_next  = ST_EMIT;
            end
            ST_SCAN: begin
                if (pend_reg) begin
                    if (CW'(al_rd_data) == CW'(sa_reg)) begin
                        found_a_next = 1'b1;
                        pos_a_next   = cmp_idx_reg;
                    end
                    if (CW'(al_rd_data) == CW'(sb_reg)) begin
                        found_b_next = 1'b1;
                    end
                end
                if (issue_reg < cnt_reg) begin
                    lctl.al_rd   = 1'b1;
                    pend_next    = 1'b1;
                    cmp_idx_next = issue_reg[IDX_W-1:0];
                    issue_next   = issue_reg + CNT_W'(1);
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        state_next = ST_FOUND;
                    end
                end
            end
            ST_FOUND: begin
                res_next   = mk_res(STAT_BAD, '0, '0, '0, 1'b0, 1'b1);
                state_next = ST_EMIT;
                case (op_reg)
                    OP_DESTROY: begin
                        if (found_a_reg && top_reg != '0) begin
                            lctl.al_rd = 1'b1;
                            al_rd_addr = IDX_W'(cnt_reg - CNT_W'(1));
                            state_next = ST_DST_MOVE;
                        end
                    end
                    OP_SET: begin
                        if (found_a_reg) begin
                            bctl.wr  = 1'b1;
                            res_next = mk_res(STAT_OK, '0, '0, '0, 1'b0, 1'b1);
                        end
                    end
                    OP_TEST: begin
                        if (found_a_reg && found_b_reg) begin
                            bctl.rd    = 1'b1;
                            state_next = ST_TST_A;
                        end
                    end
                    default: begin
                        res_next = mk_res(STAT_BAD, '0, '0, '0, 1'b0, 1'b1);
                    end
                endcase
            end
            ST_DST_MOVE: begin
                lctl.al_wr  = 1'b1;
                al_wr_addr  = pos_a_reg;
                al_wr_data  = al_rd_data;
                lctl.fs_wr  = 1'b1;
                fs_addr     = IDX_W'(top_reg - CNT_W'(1));
                top_next    = top_reg - CNT_W'(1);
                cnt_next    = cnt_reg - CNT_W'(1);
                res_next    = mk_res(STAT_OK, '0, '0, '0, 1'b0, 1'b1);
                state_next  = ST_EMIT;
            end
            ST_TST_A: begin
                bctl.hold_ref = 1'b1;
                bctl.rd       = 1'b1;
                box_rd_addr   = IDX_W'(sb_reg);
                state_next    = ST_TST_B;
            end
            ST_TST_B: begin
                res_next   = mk_res(STAT_OK, '0, sa_reg, sb_reg, overlap, 1'b1);
                state_next = ST_EMIT;
            end
            ST_SW_BASE: begin
                base_next   = al_rd_data;
                bctl.rd     = 1'b1;
                box_rd_addr = al_rd_data;
                state_next  = ST_SW_REF;
            end
            ST_SW_REF: begin
                bctl.hold_ref = 1'b1;
                j_next        = CNT_W'(row_reg) + CNT_W'(1);
                state_next    = ST_SW_LIST;
            end
            ST_SW_LIST: begin
                if (j_reg >= cnt_reg) begin
                    ret_next   = ST_IDLE;
                    state_next = ST_EMIT;
                    if (have_reg) begin
                        res_next = mk_res(STAT_OK, '0, SLOT_W'(base_reg), SLOT_W'(pair_reg),
                                          1'b1, 1'b1);
                    end else begin
                        res_next = mk_res(STAT_NO_PAIR, '0, SLOT_W'(base_reg), '0, 1'b0, 1'b1);
                    end
                end else begin
                    lctl.al_rd = 1'b1;
                    al_rd_addr = j_reg[IDX_W-1:0];
                    state_next = ST_SW_BOX;
                end
            end
            ST_SW_BOX: begin
                part_next   = al_rd_data;
                bctl.rd     = 1'b1;
                box_rd_addr = al_rd_data;
                state_next  = ST_SW_CMP;
            end
            ST_SW_CMP: begin
                j_next     = j_reg + CNT_W'(1);
                state_next = ST_SW_LIST;
                if (overlap) begin
                    pair_next = part_reg;
                    have_next = 1'b1;
                    if (have_reg) begin
                        res_next   = mk_res(STAT_OK, '0, SLOT_W'(base_reg), SLOT_W'(pair_reg),
                                            1'b1, 1'b0);
                        ret_next   = ST_SW_LIST;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_word_next  = res_reg;
                    state_next   = ret_reg;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_IDLE;
            top_reg     <= '0;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            found_a_reg <= 1'b0;
            found_b_reg <= 1'b0;
            have_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            top_reg     <= top_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            found_a_reg <= found_a_next;
            found_b_reg <= found_b_next;
            have_reg    <= have_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg      <= op_next;
        box_reg     <= box_next;
        sa_reg      <= sa_next;
        sb_reg      <= sb_next;
        row_reg     <= row_next;
        issue_reg   <= issue_next;
        j_reg       <= j_next;
        cmp_idx_reg <= cmp_idx_next;
        pos_a_reg   <= pos_a_next;
        base_reg    <= base_next;
        part_reg    <= part_next;
        pair_reg    <= pair_next;
        res_reg     <= res_next;
        m_word_reg  <= m_word_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_word_reg.status;
    assign m_new_slot    = m_word_reg.new_slot;
    assign m_pair_first  = m_word_reg.pair_first;
    assign m_pair_second = m_word_reg.pair_second;
    assign m_overlaps    = m_word_reg.overlaps;
    assign m_last        = m_word_reg.last;

    a_count_match: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == top_reg)
        else $error("active count and free top disagree");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_BOXES))
        else $error("active count beyond table size");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after accepting a word");

    a_overlap_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overlaps |-> m_status == STAT_OK)
        else $error("overlap flagged on a failing result");

endmodule
